>>> rtl/lcd_pkg.sv
package lcd_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_INIT   = 3'd1;
  localparam logic [2:0] OP_CMD    = 3'd2;
  localparam logic [2:0] OP_CHAR   = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;
  localparam logic [2:0] OP_HOME   = 3'd6;

  localparam logic [2:0] CFG_ENABLE_PHASE = 3'd0;
  localparam logic [2:0] CFG_SETTLE       = 3'd1;
  localparam logic [2:0] CFG_CLEAR_WAIT   = 3'd2;
  localparam logic [2:0] CFG_POWER_WAIT   = 3'd3;
  localparam logic [2:0] CFG_INIT_LONG    = 3'd4;
  localparam logic [2:0] CFG_INIT_SHORT   = 3'd5;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_FUNCSET  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY  = 8'h0E;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] ROW1_BASE    = 8'h80;
  localparam logic [7:0] ROW2_BASE    = 8'hC0;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [3:0] INIT_LAST    = 4'd8;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INIT,
    ACT_BYTE
  } act_t;

  typedef struct packed {
    logic       tick;
    logic       req;
    act_t       act;
    logic [7:0] value;
    logic       rs;
    logic       clear_wait;
  } item_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       rej;
  } pins_t;

endpackage

>>> rtl/lcd_front.sv
module lcd_front #(
  parameter int COLUMNS = 16
) (
  input  logic           [2:0] opcode,
  input  logic           [7:0] byte_value,
  input  logic           [1:0] row,
  input  logic           [4:0] column,
  output lcd_pkg::item_t       item
);

  localparam logic [5:0] COL_MAX = 6'(COLUMNS);

  logic       col_ok;
  logic [7:0] col_off;

  assign col_ok  = (column != 5'd0) && ({1'b0, column} <= COL_MAX);
  assign col_off = {3'b0, column - 5'd1};

  always_comb begin
    item = '0;
    item.act = lcd_pkg::ACT_NONE;
    unique case (opcode)
      lcd_pkg::OP_TICK: item.tick = 1'b1;
      lcd_pkg::OP_INIT: begin
        item.req = 1'b1;
        item.act = lcd_pkg::ACT_INIT;
      end
      lcd_pkg::OP_CMD: begin
        item.req = 1'b1;
        item.act = lcd_pkg::ACT_BYTE;
        item.value = byte_value;
      end
      lcd_pkg::OP_CHAR: begin
        item.req = 1'b1;
        item.act = lcd_pkg::ACT_BYTE;
        item.value = byte_value;
        item.rs = 1'b1;
      end
      lcd_pkg::OP_CURSOR: begin
        item.req = 1'b1;
        if ((row == 2'd1 || row == 2'd2) && col_ok) begin
          item.act = lcd_pkg::ACT_BYTE;
          item.value = ((row == 2'd1) ? lcd_pkg::ROW1_BASE : lcd_pkg::ROW2_BASE) | col_off;
        end
      end
      lcd_pkg::OP_CLEAR: begin
        item.req = 1'b1;
        item.act = lcd_pkg::ACT_BYTE;
        item.value = lcd_pkg::CMD_CLEAR;
        item.clear_wait = 1'b1;
      end
      lcd_pkg::OP_HOME: begin
        item.req = 1'b1;
        item.act = lcd_pkg::ACT_BYTE;
        item.value = lcd_pkg::CMD_HOME;
        item.clear_wait = 1'b1;
      end
      default: item = '0;
    endcase
  end

endmodule

>>> rtl/lcd_queue.sv
module lcd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcd_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lcd_pkg::item_t  head
);

  lcd_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/lcd_back.sv
module lcd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic      [2:0] cfg_index,
  input  logic     [15:0] cfg_data,
  input  logic            step,
  input  lcd_pkg::item_t  item,
  output lcd_pkg::pins_t  pins
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_POWER, PH_EN_LOW, PH_EN_HIGH, PH_SETTLE, PH_EXTRA
  } phase_t;

  logic [7:0]  enable_phase;
  logic [9:0]  settle;
  logic [15:0] clear_wait, power_wait, init_long, init_short;

  phase_t      phase, phase_next;
  logic [3:0]  init_step, init_step_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        low_next, low_next_next;
  logic [15:0] after_wait, after_wait_next;
  logic        rs_level, rs_level_next;
  logic        en_level, en_level_next;
  logic [3:0]  nib_level, nib_level_next;
  logic        rej_next;

  logic        busy;
  logic        do_init, do_byte, do_lone, do_nib, do_finish;
  logic [3:0]  init_k;
  logic [7:0]  l_byte;
  logic        l_rs;
  logic [15:0] l_extra;
  logic [3:0]  l_nib;

  assign busy = phase != PH_IDLE;

  always_comb begin
    phase_next = phase;
    init_step_next = init_step;
    wait_count_next = wait_count;
    pending_byte_next = pending_byte;
    low_next_next = low_next;
    after_wait_next = after_wait;
    rs_level_next = rs_level;
    en_level_next = en_level;
    nib_level_next = nib_level;
    rej_next = 1'b0;
    do_init = 1'b0;
    do_byte = 1'b0;
    do_lone = 1'b0;
    do_nib = 1'b0;
    do_finish = 1'b0;
    init_k = 4'd0;
    l_byte = 8'd0;
    l_rs = 1'b0;
    l_extra = 16'd0;
    l_nib = 4'd0;

    if (item.tick && busy) begin
      if (wait_count <= 16'd1) begin
        unique case (phase)
          PH_POWER: begin
            do_init = 1'b1;
            init_k = 4'd1;
          end
          PH_EN_LOW: begin
            en_level_next = 1'b1;
            phase_next = PH_EN_HIGH;
            wait_count_next = {8'd0, enable_phase};
          end
          PH_EN_HIGH: begin
            en_level_next = 1'b0;
            phase_next = PH_SETTLE;
            wait_count_next = {6'd0, settle};
          end
          PH_SETTLE: begin
            if (low_next) begin
              low_next_next = 1'b0;
              do_nib = 1'b1;
              l_nib = pending_byte[3:0];
            end else if (after_wait != 16'd0) begin
              phase_next = PH_EXTRA;
              wait_count_next = after_wait;
            end else begin
              do_finish = 1'b1;
            end
          end
          default: do_finish = 1'b1;
        endcase
      end else begin
        wait_count_next = wait_count - 16'd1;
      end
    end else if (item.req) begin
      if (busy) begin
        rej_next = 1'b1;
      end else begin
        unique case (item.act)
          lcd_pkg::ACT_INIT: begin
            rs_level_next = 1'b0;
            en_level_next = 1'b0;
            nib_level_next = 4'd0;
            low_next_next = 1'b0;
            after_wait_next = 16'd0;
            init_step_next = 4'd1;
            phase_next = PH_POWER;
            wait_count_next = power_wait;
          end
          lcd_pkg::ACT_BYTE: begin
            do_byte = 1'b1;
            l_byte = item.value;
            l_rs = item.rs;
            l_extra = item.clear_wait ? clear_wait : 16'd0;
          end
          default: ;
        endcase
      end
    end

    if (do_finish) begin
      if (init_step != 4'd0 && init_step < lcd_pkg::INIT_LAST) begin
        do_init = 1'b1;
        init_k = init_step + 4'd1;
      end else begin
        init_step_next = 4'd0;
        phase_next = PH_IDLE;
        wait_count_next = 16'd0;
      end
    end

    if (do_init) begin
      init_step_next = init_k;
      unique case (init_k)
        4'd1: begin do_lone = 1'b1; l_nib = lcd_pkg::NIB_WAKE; l_extra = init_long; end
        4'd2: begin do_lone = 1'b1; l_nib = lcd_pkg::NIB_WAKE; l_extra = init_short; end
        4'd3: begin do_lone = 1'b1; l_nib = lcd_pkg::NIB_WAKE; end
        4'd4: begin do_lone = 1'b1; l_nib = lcd_pkg::NIB_4BIT; end
        4'd5: begin do_byte = 1'b1; l_byte = lcd_pkg::CMD_FUNCSET; end
        4'd6: begin do_byte = 1'b1; l_byte = lcd_pkg::CMD_DISPLAY; end
        4'd7: begin do_byte = 1'b1; l_byte = lcd_pkg::CMD_CLEAR; l_extra = clear_wait; end
        default: begin do_byte = 1'b1; l_byte = lcd_pkg::CMD_ENTRY; end
      endcase
    end

    if (do_byte) begin
      rs_level_next = l_rs;
      pending_byte_next = l_byte;
      low_next_next = 1'b1;
      after_wait_next = l_extra;
      l_nib = l_byte[7:4];
    end else if (do_lone) begin
      rs_level_next = 1'b0;
      low_next_next = 1'b0;
      after_wait_next = l_extra;
    end

    if (do_byte || do_lone || do_nib) begin
      nib_level_next = l_nib;
      en_level_next = 1'b0;
      phase_next = PH_EN_LOW;
      wait_count_next = {8'd0, enable_phase};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_phase <= 8'd10;
      settle       <= 10'd100;
      clear_wait   <= 16'd2000;
      power_wait   <= 16'd40000;
      init_long    <= 16'd5000;
      init_short   <= 16'd150;
    end else if (cfg_write) begin
      case (cfg_index)
        lcd_pkg::CFG_ENABLE_PHASE: enable_phase <= cfg_data[7:0];
        lcd_pkg::CFG_SETTLE:       settle <= cfg_data[9:0];
        lcd_pkg::CFG_CLEAR_WAIT:   clear_wait <= cfg_data;
        lcd_pkg::CFG_POWER_WAIT:   power_wait <= cfg_data;
        lcd_pkg::CFG_INIT_LONG:    init_long <= cfg_data;
        lcd_pkg::CFG_INIT_SHORT:   init_short <= {6'd0, cfg_data[9:0]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      init_step <= 4'd0;
      wait_count <= 16'd0;
      pending_byte <= 8'd0;
      low_next <= 1'b0;
      after_wait <= 16'd0;
      rs_level <= 1'b0;
      en_level <= 1'b0;
      nib_level <= 4'd0;
      pins <= '0;
    end else if (step) begin
      phase <= phase_next;
      init_step <= init_step_next;
      wait_count <= wait_count_next;
      pending_byte <= pending_byte_next;
      low_next <= low_next_next;
      after_wait <= after_wait_next;
      rs_level <= rs_level_next;
      en_level <= en_level_next;
      nib_level <= nib_level_next;
      pins.rs <= rs_level_next;
      pins.en <= en_level_next;
      pins.nib <= nib_level_next;
      pins.busy <= phase_next != PH_IDLE;
      pins.rej <= rej_next;
    end
  end

endmodule

>>> rtl/char_lcd_nibble_interface_core.sv
// Path: a transfer in is written to the two-entry queue, and a later back step pops it and
// loads the result register, which then offers the result.
// Throughput: one item per cycle while results are taken; a held result stalls the back,
// the queue fills after two more items and then holds the input.
// Reset: synchronous, active high; registers return to their reset values, the
// queue and output register empty, and the display state goes idle.
module char_lcd_nibble_interface_core #(
  parameter int COLUMNS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic  [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic  [2:0] opcode,
  input  logic  [7:0] byte_value,
  input  logic  [1:0] row,
  input  logic  [4:0] column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_select,
  output logic        read_write,
  output logic        enable_pin,
  output logic  [3:0] data_nibble,
  output logic        busy_res,
  output logic        rejected
);

  lcd_pkg::item_t in_item, head;
  lcd_pkg::pins_t pins;
  logic           full, empty, step;

  lcd_front #(.COLUMNS(COLUMNS)) u_front (
    .opcode(opcode), .byte_value(byte_value), .row(row), .column(column), .item(in_item)
  );

  assign in_ready = ~full;
  assign step = ~empty && (~out_valid || out_ready);

  lcd_queue u_queue (
    .clk(clk), .rst(rst), .push(in_valid && in_ready), .push_item(in_item),
    .full(full), .pop(step), .empty(empty), .head(head)
  );

  lcd_back u_back (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .step(step), .item(head), .pins(pins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign reg_select  = pins.rs;
  assign read_write  = 1'b0;
  assign enable_pin  = pins.en;
  assign data_nibble = pins.nib;
  assign busy_res    = pins.busy;
  assign rejected    = pins.rej;

endmodule

>>> test/tb_char_lcd_nibble_interface_core.sv
module tb_char_lcd_nibble_interface_core;

  localparam int COLS = 16;
  localparam int STALL_LIMIT = 400000;
  localparam logic [2:0] OP_UNDEF = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE, PH_POWER, PH_EN_LOW, PH_EN_HIGH, PH_SETTLE, PH_EXTRA
  } lcd_phase_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [3:0] nib;
    logic       busy;
    logic       rej;
  } pin_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic  [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic  [2:0] opcode = '0;
  logic  [7:0] byte_value = '0;
  logic  [1:0] row = '0;
  logic  [4:0] column = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        reg_select, read_write, enable_pin, busy_res, rejected;
  logic  [3:0] data_nibble;

  char_lcd_nibble_interface_core #(.COLUMNS(COLS)) u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // display state mirror
  logic  [7:0] m_phase_us;
  logic  [9:0] m_settle_us, m_short_us;
  logic [15:0] m_clear_us, m_power_us, m_long_us;
  lcd_phase_t  m_phase;
  logic  [3:0] m_step;
  logic [15:0] m_count, m_after;
  logic  [7:0] m_byte;
  logic        m_low_next, m_rs, m_en;
  logic  [3:0] m_nib;

  pin_state_t pins_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;
  int checked = 0;
  int stall = 0;

  task automatic mirror_reset();
    m_phase_us = 8'd10; m_settle_us = 10'd100; m_clear_us = 16'd2000;
    m_power_us = 16'd40000; m_long_us = 16'd5000; m_short_us = 10'd150;
    m_phase = PH_IDLE; m_step = 0; m_count = 0; m_byte = 0;
    m_low_next = 0; m_after = 0; m_rs = 0; m_en = 0; m_nib = 0;
  endtask

  task automatic start_nibble(logic [3:0] n);
    m_nib = n; m_en = 0; m_phase = PH_EN_LOW; m_count = 16'(m_phase_us);
  endtask

  task automatic start_byte(logic [7:0] b, logic rs, logic [15:0] extra);
    m_rs = rs; m_byte = b; m_low_next = 1; m_after = extra;
    start_nibble(b[7:4]);
  endtask

  task automatic start_lone(logic [3:0] n, logic [15:0] extra);
    m_rs = 0; m_low_next = 0; m_after = extra;
    start_nibble(n);
  endtask

  task automatic start_init_step(logic [3:0] k);
    m_step = k;
    case (k)
      4'd1: start_lone(lcd_pkg::NIB_WAKE, m_long_us);
      4'd2: start_lone(lcd_pkg::NIB_WAKE, 16'(m_short_us));
      4'd3: start_lone(lcd_pkg::NIB_WAKE, 16'd0);
      4'd4: start_lone(lcd_pkg::NIB_4BIT, 16'd0);
      4'd5: start_byte(lcd_pkg::CMD_FUNCSET, 1'b0, 16'd0);
      4'd6: start_byte(lcd_pkg::CMD_DISPLAY, 1'b0, 16'd0);
      4'd7: start_byte(lcd_pkg::CMD_CLEAR, 1'b0, m_clear_us);
      default: start_byte(lcd_pkg::CMD_ENTRY, 1'b0, 16'd0);
    endcase
  endtask

  task automatic finish_step();
    if (m_step != 0 && m_step < lcd_pkg::INIT_LAST) begin
      start_init_step(m_step + 4'd1);
    end else begin
      m_step = 0; m_phase = PH_IDLE; m_count = 0;
    end
  endtask

  task automatic expire_wait();
    case (m_phase)
      PH_POWER: start_init_step(4'd1);
      PH_EN_LOW: begin
        m_en = 1; m_phase = PH_EN_HIGH; m_count = 16'(m_phase_us);
      end
      PH_EN_HIGH: begin
        m_en = 0; m_phase = PH_SETTLE; m_count = 16'(m_settle_us);
      end
      PH_SETTLE: begin
        if (m_low_next) begin
          m_low_next = 0;
          start_nibble(m_byte[3:0]);
        end else if (m_after != 0) begin
          m_phase = PH_EXTRA; m_count = m_after;
        end else begin
          finish_step();
        end
      end
      default: finish_step();
    endcase
  endtask

  task automatic predict_pins(logic [2:0] op, logic [7:0] b, logic [1:0] r, logic [4:0] c);
    pin_state_t p;
    logic busy;
    busy = (m_phase != PH_IDLE);
    p.rej = 1'b0;
    if (op == lcd_pkg::OP_TICK) begin
      if (busy) begin
        if (m_count <= 1) expire_wait();
        else m_count--;
      end
    end else if (op <= lcd_pkg::OP_HOME) begin
      if (busy) begin
        p.rej = 1'b1;
      end else begin
        case (op)
          lcd_pkg::OP_INIT: begin
            m_rs = 0; m_en = 0; m_nib = 0; m_low_next = 0; m_after = 0;
            m_step = 1; m_phase = PH_POWER; m_count = m_power_us;
          end
          lcd_pkg::OP_CMD: start_byte(b, 1'b0, 16'd0);
          lcd_pkg::OP_CHAR: start_byte(b, 1'b1, 16'd0);
          lcd_pkg::OP_CURSOR: begin
            if ((r == 2'd1 || r == 2'd2) && c >= 1 && c <= COLS)
              start_byte(((r == 2'd1) ? lcd_pkg::ROW1_BASE : lcd_pkg::ROW2_BASE) |
                         8'(c - 5'd1), 1'b0, 16'd0);
          end
          lcd_pkg::OP_CLEAR: start_byte(lcd_pkg::CMD_CLEAR, 1'b0, m_clear_us);
          default: start_byte(lcd_pkg::CMD_HOME, 1'b0, m_clear_us);
        endcase
      end
    end
    p.rs = m_rs; p.rw = 1'b0; p.en = m_en; p.nib = m_nib;
    p.busy = (m_phase != PH_IDLE);
    pins_q.push_back(p);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s on result %0d: got %0d want %0d", what, checked, got, want);
  endtask

  task automatic send_item(logic [2:0] op, logic [7:0] b, logic [1:0] r, logic [4:0] c);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode <= op; byte_value <= b; row <= r; column <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pins(op, b, r, c);
    sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      lcd_pkg::CFG_ENABLE_PHASE: m_phase_us = val[7:0];
      lcd_pkg::CFG_SETTLE: m_settle_us = val[9:0];
      lcd_pkg::CFG_CLEAR_WAIT: m_clear_us = val;
      lcd_pkg::CFG_POWER_WAIT: m_power_us = val;
      lcd_pkg::CFG_INIT_LONG: m_long_us = val;
      lcd_pkg::CFG_INIT_SHORT: m_short_us = val[9:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pins_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic tick_until_idle();
    int n;
    n = 0;
    while (m_phase != PH_IDLE && n < 5000) begin
      send_item(lcd_pkg::OP_TICK, 8'($urandom), 2'($urandom), 5'($urandom));
      n++;
    end
  endtask

  task automatic set_timing(logic [15:0] ph, logic [15:0] st, logic [15:0] cw,
                            logic [15:0] pw, logic [15:0] lw, logic [15:0] sw);
    drain_results();
    write_reg(lcd_pkg::CFG_ENABLE_PHASE, ph);
    write_reg(lcd_pkg::CFG_SETTLE, st);
    write_reg(lcd_pkg::CFG_CLEAR_WAIT, cw);
    write_reg(lcd_pkg::CFG_POWER_WAIT, pw);
    write_reg(lcd_pkg::CFG_INIT_LONG, lw);
    write_reg(lcd_pkg::CFG_INIT_SHORT, sw);
  endtask

  task automatic test_directed();
    set_timing(16'd1, 16'd1, 16'd2, 16'd1, 16'd0, 16'd0);
    send_item(lcd_pkg::OP_TICK, 8'h00, 2'd0, 5'd0);
    send_item(lcd_pkg::OP_INIT, 8'hFF, 2'd3, 5'd31);
    send_item(lcd_pkg::OP_CMD, 8'h00, 2'd0, 5'd0);
    tick_until_idle();
    send_item(lcd_pkg::OP_CMD, 8'hFF, 2'd0, 5'd0);
    send_item(lcd_pkg::OP_CHAR, 8'h00, 2'd0, 5'd0);
    tick_until_idle();
    send_item(lcd_pkg::OP_CHAR, 8'hA5, 2'd0, 5'd0);
    tick_until_idle();
    send_item(lcd_pkg::OP_CMD, lcd_pkg::CMD_CLEAR, 2'd0, 5'd0);
    tick_until_idle();
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd1, 5'd1);
    tick_until_idle();
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd2, 5'd16);
    tick_until_idle();
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd0, 5'd3);
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd3, 5'd3);
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd1, 5'd0);
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd2, 5'd17);
    send_item(lcd_pkg::OP_CURSOR, 8'h00, 2'd2, 5'd31);
    send_item(OP_UNDEF, 8'h5A, 2'd1, 5'd1);
    send_item(lcd_pkg::OP_CLEAR, 8'h00, 2'd0, 5'd0);
    send_item(lcd_pkg::OP_HOME, 8'h00, 2'd0, 5'd0);
    tick_until_idle();
    send_item(lcd_pkg::OP_HOME, 8'h00, 2'd0, 5'd0);
    tick_until_idle();
  endtask

  task automatic random_burst(int count);
    int i;
    logic [2:0] op;
    for (i = 0; i < count; i++) begin
      if (m_phase == PH_IDLE || $urandom_range(9) == 0) begin
        op = 3'($urandom_range(7));
        if (op == lcd_pkg::OP_TICK) op = 3'($urandom_range(1, 6));
        if (op == lcd_pkg::OP_INIT && $urandom_range(3) != 0) op = lcd_pkg::OP_CHAR;
      end else begin
        op = lcd_pkg::OP_TICK;
      end
      send_item(op, 8'($urandom), 2'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_random(int s_pct, int r_pct, int count);
    send_idle_pct = s_pct; recv_idle_pct = r_pct;
    random_burst(count);
    tick_until_idle();
  endtask

  initial begin
    logic [15:0] ph;
    mirror_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(27, 66, 400);
    set_timing(16'hFF00, 16'hFC00, 16'd0, 16'd0, 16'd0, 16'hFC00);
    test_random(66, 27, 100);
    set_timing(16'd3, 16'd5, 16'd30, 16'd20, 16'd25, 16'd7);
    test_random(66, 27, 350);
    ph = 16'($urandom_range(1, 4));
    set_timing(ph, 16'd2, 16'd9, 16'd6, 16'd4, 16'd3);
    test_random(0, 0, 600);
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d transfers in, %0d results checked, all opcodes, zero and",
             sent, checked);
    $display("truncated timing writes, under sender-heavy, receiver-heavy and no idling");
    if (errors == 0) begin
      $display("tb_char_lcd_nibble_interface_core OK");
    end else begin
      $display("tb_char_lcd_nibble_interface_core NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pin_state_t w;
    if (!rst && out_valid && out_ready) begin
      if (pins_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pins_q.pop_front();
        if (reg_select !== w.rs) report_mismatch("reg_select", reg_select, w.rs);
        if (read_write !== w.rw) report_mismatch("read_write", read_write, w.rw);
        if (enable_pin !== w.en) report_mismatch("enable_pin", enable_pin, w.en);
        if (data_nibble !== w.nib) report_mismatch("data_nibble", data_nibble, w.nib);
        if (busy_res !== w.busy) report_mismatch("busy_res", busy_res, w.busy);
        if (rejected !== w.rej) report_mismatch("rejected", rejected, w.rej);
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || rst) begin
      stall <= 0;
    end else begin
      stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
        $display("tb_char_lcd_nibble_interface_core NOT OK");
        $finish;
      end
    end
  end

endmodule
